### rtl/daos_pkg.sv
// shared types, constants and helpers for the atom orientation search
package daos_pkg;

   localparam int GRID        = 8;
   localparam int CELLS       = GRID * GRID;
   localparam int MAX_ATOMS   = 256;
   localparam int CELL_W      = $clog2(CELLS);
   localparam int ATOM_IDX_W  = $clog2(MAX_ATOMS);
   localparam int ATOM_ADDR_W = ATOM_IDX_W + CELL_W;
   localparam int COUNT_W     = ATOM_IDX_W + 1;
   localparam int COEF_W      = 16;
   localparam int SAMPLE_W    = 10;
   localparam int PROD_W      = COEF_W + SAMPLE_W;
   localparam int ACC_W       = PROD_W + CELL_W;
   localparam int SCORE_W     = 30;
   localparam int GEOMS       = 8;
   localparam int CODE_W      = 4;
   localparam int OP_W        = 2;

   localparam logic [SCORE_W-1:0] SCORE_MAX = '1;

   typedef enum logic [OP_W-1:0] {
      OP_WRITE_ATOM   = 2'd0,
      OP_WRITE_TARGET = 2'd1,
      OP_SEARCH       = 2'd2,
      OP_NONE         = 2'd3
   } daos_op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ACCUM,
      ST_DRAIN,
      ST_COMPARE,
      ST_RESP
   } daos_state_type;

   typedef struct packed {
      logic                  atom_we;
      logic                  target_we;
      logic                  search_init;
      logic                  rd_en;
      logic [ATOM_IDX_W-1:0] rd_atom;
      logic [CELL_W-1:0]     rd_cell;
      logic                  acc_clear;
      logic                  cmp_en;
      logic [CODE_W-1:0]     cmp_code;
   } daos_cmd_type;

   typedef struct packed {
      logic busy;
   } daos_status_type;

   // atom cell paired with target cell pos under geometry code
   function automatic logic [CELL_W-1:0] orient_cell(input logic [2:0] code,
                                                     input logic [CELL_W-1:0] pos);
      logic [2:0] r;
      logic [2:0] c;
      logic [2:0] ar;
      logic [2:0] ac;
      r = pos[5:3];
      c = pos[2:0];
      unique case (code)
         3'd0: begin ar = r;  ac = c;  end
         3'd1: begin ar = ~r; ac = ~c; end
         3'd2: begin ar = r;  ac = ~c; end
         3'd3: begin ar = ~r; ac = c;  end
         3'd4: begin ar = c;  ac = r;  end
         3'd5: begin ar = ~c; ac = ~r; end
         3'd6: begin ar = ~c; ac = r;  end
         default: begin ar = c; ac = ~r; end
      endcase
      return {ar, ac};
   endfunction

endpackage

### rtl/dictionary_atom_orientation_search_unit.sv
// Top level of the atom orientation search.
// Write items (atom coefficient or target sample) are taken only while idle.
// A search walks each of the n atoms in turn, n the clamped atom count:
// per atom it reads all 64 cells through the single atom store read port, drains
// the multiply pipeline and compares the 16 orientations; one item at a time.
// Reset clears the controller state and the atom count; both stores are undefined until written.
module dictionary_atom_orientation_search_unit import daos_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [OP_W-1:0]            req_op,
   input  logic [ATOM_IDX_W-1:0]      req_atom_index,
   input  logic [CELL_W-1:0]          req_position,
   input  logic signed [COEF_W-1:0]   req_atom_value,
   input  logic signed [SAMPLE_W-1:0] req_sample,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [ATOM_IDX_W-1:0]      rsp_best_atom,
   output logic [CODE_W-1:0]          rsp_orientation,
   output logic [SCORE_W-1:0]         rsp_score,
   input  logic                       csr_write_enable,
   input  logic [COUNT_W-1:0]         csr_write_data
);

   daos_cmd_type    cmd;
   daos_status_type status;

   // sequencing
   daos_ctrl u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_op           (req_op),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .status           (status),
      .cmd              (cmd)
   );

   // stores and arithmetic
   daos_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_atom_index  (req_atom_index),
      .req_position    (req_position),
      .req_atom_value  (req_atom_value),
      .req_sample      (req_sample),
      .rsp_best_atom   (rsp_best_atom),
      .rsp_orientation (rsp_orientation),
      .rsp_score       (rsp_score)
   );

endmodule

### rtl/daos_ram.sv
// generic single write port ram with registered read
module daos_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // write and registered read
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

### rtl/daos_ctrl.sv
// controller: handshakes, atom count register and search sequencing
module daos_ctrl import daos_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  logic [OP_W-1:0] req_op,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   input  logic            csr_write_enable,
   input  logic [COUNT_W-1:0] csr_write_data,
   input  daos_status_type status,
   output daos_cmd_type    cmd
);

   daos_state_type state_ff, state_in;
   logic [COUNT_W-1:0]    count_ff, count_in;
   logic [COUNT_W-1:0]    n_ff, n_in;
   logic [ATOM_IDX_W-1:0] atom_ff, atom_in;
   logic [CELL_W-1:0]     cell_ff, cell_in;
   logic [CODE_W-1:0]     code_ff, code_in;
   logic                  accept;
   logic [COUNT_W-1:0]    n_clamp;
   logic                  last_atom;

   assign accept    = req_valid && req_ready;
   assign n_clamp   = (count_ff > COUNT_W'(MAX_ATOMS)) ? COUNT_W'(MAX_ATOMS) : count_ff;
   assign last_atom = ({1'b0, atom_ff} == (n_ff - COUNT_W'(1)));

   // state and counters
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
      n_ff    <= n_in;
      atom_ff <= atom_in;
      cell_ff <= cell_in;
      code_ff <= code_in;
   end

   // next state and commands
   always_comb begin
      state_in  = state_ff;
      count_in  = csr_write_enable ? csr_write_data : count_ff;
      n_in      = n_ff;
      atom_in   = atom_ff;
      cell_in   = cell_ff;
      code_in   = code_ff;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      cmd       = '0;
      cmd.rd_atom  = atom_ff;
      cmd.rd_cell  = cell_ff;
      cmd.cmp_code = code_ff;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (accept) begin
               unique case (daos_op_type'(req_op))
                  OP_WRITE_ATOM:   cmd.atom_we = 1'b1;
                  OP_WRITE_TARGET: cmd.target_we = 1'b1;
                  OP_SEARCH: begin
                     cmd.search_init = 1'b1;
                     n_in    = n_clamp;
                     atom_in = '0;
                     cell_in = '0;
                     state_in = (n_clamp == '0) ? ST_RESP : ST_ACCUM;
                  end
                  default: ;
               endcase
            end
         end
         ST_ACCUM: begin
            cmd.rd_en     = 1'b1;
            cmd.acc_clear = (cell_ff == '0);
            cell_in       = cell_ff + CELL_W'(1);
            if (cell_ff == CELL_W'(CELLS - 1)) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            code_in = '0;
            if (!status.busy) begin
               state_in = ST_COMPARE;
            end
         end
         ST_COMPARE: begin
            cmd.cmp_en = 1'b1;
            code_in    = code_ff + CODE_W'(1);
            if (code_ff == '1) begin
               if (last_atom) begin
                  state_in = ST_RESP;
               end else begin
                  atom_in  = atom_ff + ATOM_IDX_W'(1);
                  cell_in  = '0;
                  state_in = ST_ACCUM;
               end
            end
         end
         ST_RESP: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

### rtl/daos_datapath.sv
// datapath: atom and target stores, eight multiply-accumulate lanes, best tracker
module daos_datapath import daos_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  daos_cmd_type               cmd,
   output daos_status_type            status,
   input  logic [ATOM_IDX_W-1:0]      req_atom_index,
   input  logic [CELL_W-1:0]          req_position,
   input  logic signed [COEF_W-1:0]   req_atom_value,
   input  logic signed [SAMPLE_W-1:0] req_sample,
   output logic [ATOM_IDX_W-1:0]      rsp_best_atom,
   output logic [CODE_W-1:0]          rsp_orientation,
   output logic [SCORE_W-1:0]         rsp_score
);

   logic [COEF_W-1:0]   atom_rd;
   logic [SAMPLE_W-1:0] tgt_rd [GEOMS];
   logic                rd_v_ff;
   logic                prod_v_ff;
   logic signed [PROD_W-1:0] prod_ff [GEOMS];
   logic signed [ACC_W-1:0]  acc_ff  [GEOMS];
   logic signed [ACC_W-1:0]  best_ff;
   logic [ATOM_IDX_W-1:0]    best_atom_ff;
   logic [CODE_W-1:0]        best_code_ff;
   logic                     have_ff;
   logic [ATOM_IDX_W-1:0]    cmp_atom_ff;
   logic signed [ACC_W-1:0]  cand;

   // atom coefficient store
   daos_ram #(.WIDTH(COEF_W), .DEPTH(MAX_ATOMS * CELLS)) u_atom_ram (
      .clock (clock),
      .we    (cmd.atom_we),
      .waddr ({req_atom_index, req_position}),
      .wdata (req_atom_value),
      .raddr ({cmd.rd_atom, cmd.rd_cell}),
      .rdata (atom_rd)
   );

   // one target copy per geometry, stored at the atom cell it pairs with
   for (genvar k = 0; k < GEOMS; k++) begin : g_tgt
      daos_ram #(.WIDTH(SAMPLE_W), .DEPTH(CELLS)) u_tgt_ram (
         .clock (clock),
         .we    (cmd.target_we),
         .waddr (orient_cell(3'(k), req_position)),
         .wdata (req_sample),
         .raddr (cmd.rd_cell),
         .rdata (tgt_rd[k])
      );
   end

   // pipeline valid flags
   always_ff @(posedge clock) begin
      if (reset) begin
         rd_v_ff   <= 1'b0;
         prod_v_ff <= 1'b0;
      end else begin
         rd_v_ff   <= cmd.rd_en;
         prod_v_ff <= rd_v_ff;
      end
   end

   assign status.busy = rd_v_ff || prod_v_ff;

   // multiply and accumulate lanes
   always_ff @(posedge clock) begin
      for (int k = 0; k < GEOMS; k++) begin
         prod_ff[k] <= $signed(atom_rd) * $signed(tgt_rd[k]);
         if (cmd.acc_clear) begin
            acc_ff[k] <= '0;
         end else if (prod_v_ff) begin
            acc_ff[k] <= acc_ff[k] + ACC_W'(prod_ff[k]);
         end
      end
   end

   // candidate for the current orientation, negated for the upper eight
   always_comb begin
      cand = acc_ff[cmd.cmp_code[2:0]];
      if (cmd.cmp_code[3]) begin
         cand = -cand;
      end
   end

   // best tracker, first strict maximum wins
   always_ff @(posedge clock) begin
      if (cmd.rd_en) begin
         cmp_atom_ff <= cmd.rd_atom;
      end
      if (cmd.search_init) begin
         have_ff      <= 1'b0;
         best_ff      <= '0;
         best_atom_ff <= '0;
         best_code_ff <= '0;
      end else if (cmd.cmp_en && (!have_ff || cand > best_ff)) begin
         have_ff      <= 1'b1;
         best_ff      <= cand;
         best_atom_ff <= cmp_atom_ff;
         best_code_ff <= cmd.cmp_code;
      end
   end

   // result with clamp to zero and saturation
   always_comb begin
      rsp_best_atom   = best_atom_ff;
      rsp_orientation = best_code_ff;
      if (best_ff < 0) begin
         rsp_score = '0;
      end else if (best_ff > $signed({{(ACC_W-SCORE_W){1'b0}}, SCORE_MAX})) begin
         rsp_score = SCORE_MAX;
      end else begin
         rsp_score = best_ff[SCORE_W-1:0];
      end
   end

endmodule
